### hdl/devc_pkg.sv
// ----------------------------------------------------------------------------
// Dual encoder volume control package
// Shared types, register codes, widths and the quadrature direction table.
// ----------------------------------------------------------------------------
package devc_pkg;

    localparam int unsigned NUM_CH     = 2;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned DETENT_W   = 3;
    localparam int unsigned SUM_W      = 4;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [LEVEL_W-1:0]    LEVEL_RESET        = 8'd20;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RESET  = 16'd25;
    localparam logic [LEVEL_W-1:0]    LEVEL_STEP_RESET   = 8'd4;
    localparam logic [LEVEL_W-1:0]    LEVEL_MAX_RESET    = 8'd200;
    localparam logic [DETENT_W-1:0]   DETENT_COUNT_RESET = 3'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_MS  = 4'd0,
        REG_LEVEL_STEP   = 4'd1,
        REG_LEVEL_MAX    = 4'd2,
        REG_DETENT_COUNT = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [LEVEL_W-1:0]    level_step;
        logic [LEVEL_W-1:0]    level_max;
        logic [DETENT_W-1:0]   detent_count;
    } t_cfg;

    // What one channel lane found for the current sample.
    typedef struct packed {
        logic               step_up;
        logic               step_dn;
        logic [LEVEL_W-1:0] level;    // level after a step, or unchanged
        logic               pressed;  // debounced press accepted
        logic               stable;   // debounced button state after sample
    } t_lane_res;

    typedef struct packed {
        logic               levels_zeroed;
        logic               mic_muted;
        logic               speaker_muted;
        logic [LEVEL_W-1:0] mic_level;
        logic [LEVEL_W-1:0] speaker_level;
        logic               mute_pulse;
        logic               volume_down_pulse;
        logic               volume_up_pulse;
    } t_result;

    // Direction per {previous phase, current phase}, phase = {A, B}.
    localparam logic signed [1:0] PHASE_DIR [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

endpackage

### hdl/dual_encoder_volume_control_core.sv
// ----------------------------------------------------------------------------
// Dual encoder volume control core
// Two rotary encoder lanes with a merge stage and a buffered result stream.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_axis channel is one pin sample: a millisecond
// timestamp plus the A, B and button pins of the speaker and microphone
// encoders. Every sample yields exactly one result transfer on m_axis,
// carrying the step and mute pulses, both levels, both mute flags and the
// zeroing flag, in sample order.
// The two channel lanes and the merge stage finish a sample in the cycle it
// is accepted, and the result is registered on the result path, so one sample
// can be accepted every cycle while s_axis_tready stays high. The rate is set
// by the state update of the lanes and the merge registers.
// The result path is an output register backed by one skid register. When
// the receiver stalls, one more sample is still taken into the skid stage;
// s_axis_tready then drops until the output register drains.
// The configuration channel writes one register per transfer and is always
// ready; it should be used only while no sample is in flight.
// A synchronous active-low reset restores default configuration, levels of
// 20, cleared mute flags, released buttons and empty result buffers.
// ----------------------------------------------------------------------------
module dual_encoder_volume_control_core
    import devc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] now_ms, [32] spk_pin_a, [33] spk_pin_b, [34] spk_button_pin,
    // [35] mic_pin_a, [36] mic_pin_b, [37] mic_button_pin, [39:38] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] volume_up_pulse, [1] volume_down_pulse, [2] mute_pulse,
    // [10:3] speaker_level, [18:11] mic_level, [19] speaker_muted,
    // [20] mic_muted, [21] levels_zeroed, [23:22] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      in_accept, out_take;
    t_lane_res spk_res, mic_res;
    t_result   result;
    logic [LEVEL_W-1:0] spk_level, mic_level;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_result   r_out, r_skid;
    logic      load_out, load_skid, skid_to_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms  <= DEBOUNCE_MS_RESET;
            r_cfg.level_step   <= LEVEL_STEP_RESET;
            r_cfg.level_max    <= LEVEL_MAX_RESET;
            r_cfg.detent_count <= DETENT_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE_MS:  r_cfg.debounce_ms  <= i_cfg_data;
                REG_LEVEL_STEP:   r_cfg.level_step   <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_MAX:    r_cfg.level_max    <= i_cfg_data[LEVEL_W-1:0];
                REG_DETENT_COUNT: r_cfg.detent_count <= i_cfg_data[DETENT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    // Speaker lane.
    devc_lane u_lane_spk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_accept),
        .i_cfg   (r_cfg),
        .i_now   (s_axis_tdata[TIME_W-1:0]),
        .i_pin_a (s_axis_tdata[32]),
        .i_pin_b (s_axis_tdata[33]),
        .i_btn   (s_axis_tdata[34]),
        .i_level (spk_level),
        .o_res   (spk_res)
    );

    // Microphone lane.
    devc_lane u_lane_mic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_accept),
        .i_cfg   (r_cfg),
        .i_now   (s_axis_tdata[TIME_W-1:0]),
        .i_pin_a (s_axis_tdata[35]),
        .i_pin_b (s_axis_tdata[36]),
        .i_btn   (s_axis_tdata[37]),
        .i_level (mic_level),
        .o_res   (mic_res)
    );

    devc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_accept),
        .i_spk       (spk_res),
        .i_mic       (mic_res),
        .i_spk_btn   (s_axis_tdata[34]),
        .i_mic_btn   (s_axis_tdata[37]),
        .o_spk_level (spk_level),
        .o_mic_level (mic_level),
        .o_res       (result)
    );

    // Output register with one skid entry behind it. The skid entry only
    // fills when a new sample arrives while the output is held.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        skid_to_out  = 1'b0;
        if (out_take) begin
            if (r_skid_valid) begin
                skid_to_out  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (in_accept) begin
            if (r_out_valid && !out_take) begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end else begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= result;
        end else if (skid_to_out) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

    // The skid entry is never occupied while the output register is empty.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // A sample taken into an empty result path is offered next cycle.
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_out_valid) |=> (m_axis_tvalid && !r_skid_valid))
        else $error("accepted sample not presented");

    // Zeroing forces both levels to zero and suppresses the mute toggle.
    a_zero_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.levels_zeroed) |->
        (r_out.speaker_level == '0 && r_out.mic_level == '0 && !r_out.mute_pulse))
        else $error("zeroing result carries nonzero level or mute pulse");

    // A speaker step is either up or down, never both.
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out.volume_up_pulse && r_out.volume_down_pulse))
        else $error("speaker stepped both up and down");

endmodule

### hdl/devc_lane.sv
// ----------------------------------------------------------------------------
// Encoder channel lane
// Quadrature decode, detent accumulation, level step and button debounce.
// ----------------------------------------------------------------------------
module devc_lane
    import devc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic [TIME_W-1:0]  i_now,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    input  logic               i_btn,
    input  logic [LEVEL_W-1:0] i_level,
    output t_lane_res          o_res
);

    logic [1:0]        r_prev_phase, n_prev_phase;
    logic [SUM_W-1:0]  r_step_sum,   n_step_sum;
    logic              r_stable,     n_stable;
    logic              r_last_raw,   n_last_raw;
    logic [TIME_W-1:0] r_chg_time,   n_chg_time;

    logic [1:0]              cur_phase;
    logic signed [1:0]       dir;
    logic signed [SUM_W:0]   sum;
    logic signed [SUM_W:0]   detent;
    logic                    up, dn;
    logic [LEVEL_W:0]        up_val;
    logic [LEVEL_W-1:0]      dn_val;
    logic [LEVEL_W-1:0]      raw_level;
    logic [TIME_W-1:0]       elapsed;
    logic                    accept_btn;

    assign cur_phase = {i_pin_a, i_pin_b};
    assign dir       = PHASE_DIR[{r_prev_phase, cur_phase}];
    assign sum       = $signed({r_step_sum[SUM_W-1], r_step_sum})
                     + $signed({{(SUM_W-1){dir[1]}}, dir});
    // A detent count of zero behaves as one.
    assign detent    = (i_cfg.detent_count == '0) ? (SUM_W+1)'(1)
                     : $signed({{(SUM_W+1-DETENT_W){1'b0}}, i_cfg.detent_count});
    assign up        = (sum >= detent);
    assign dn        = !up && (sum <= -detent);

    assign up_val = {1'b0, i_level} + {1'b0, i_cfg.level_step};
    assign dn_val = (i_level >= i_cfg.level_step) ? i_level - i_cfg.level_step : '0;

    always_comb begin
        raw_level = i_level;
        if (up) begin
            raw_level = (up_val > {1'b0, i_cfg.level_max}) ? i_cfg.level_max
                                                          : up_val[LEVEL_W-1:0];
        end else if (dn) begin
            raw_level = (dn_val > i_cfg.level_max) ? i_cfg.level_max : dn_val;
        end
    end

    // A fresh raw change restarts the hold time before the check.
    assign n_last_raw = i_btn;
    assign n_chg_time = (i_btn != r_last_raw) ? i_now : r_chg_time;
    assign elapsed    = i_now - n_chg_time;
    assign accept_btn = (elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, i_cfg.debounce_ms})
                     && (i_btn != r_stable);
    assign n_stable   = accept_btn ? i_btn : r_stable;

    assign n_prev_phase = cur_phase;
    assign n_step_sum   = (up || dn) ? '0 : sum[SUM_W-1:0];

    assign o_res.step_up = up;
    assign o_res.step_dn = dn;
    assign o_res.level   = raw_level;
    assign o_res.pressed = accept_btn && !i_btn;
    assign o_res.stable  = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase <= '0;
            r_step_sum   <= '0;
            r_stable     <= 1'b1;
            r_last_raw   <= 1'b1;
            r_chg_time   <= '0;
        end else if (i_en) begin
            r_prev_phase <= n_prev_phase;
            r_step_sum   <= n_step_sum;
            r_stable     <= n_stable;
            r_last_raw   <= n_last_raw;
            r_chg_time   <= n_chg_time;
        end
    end

endmodule

### hdl/devc_merge.sv
// ----------------------------------------------------------------------------
// Lane merge stage
// Holds levels and mute flags, applies both-button zeroing and mute toggles.
// ----------------------------------------------------------------------------
module devc_merge
    import devc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_lane_res          i_spk,
    input  t_lane_res          i_mic,
    input  logic               i_spk_btn,
    input  logic               i_mic_btn,
    output logic [LEVEL_W-1:0] o_spk_level,
    output logic [LEVEL_W-1:0] o_mic_level,
    output t_result            o_res
);

    logic [LEVEL_W-1:0] r_spk_level, n_spk_level;
    logic [LEVEL_W-1:0] r_mic_level, n_mic_level;
    logic               r_spk_muted, n_spk_muted;
    logic               r_mic_muted, n_mic_muted;
    logic               r_both_done, n_both_done;
    logic               zeroed, spk_toggle, mic_toggle;

    assign o_spk_level = r_spk_level;
    assign o_mic_level = r_mic_level;

    always_comb begin
        n_spk_level = i_spk.level;
        n_mic_level = i_mic.level;
        n_both_done = r_both_done;
        zeroed      = 1'b0;
        if (!(!i_spk.stable && !i_mic.stable)) begin
            n_both_done = 1'b0;
        end else if (!r_both_done) begin
            n_spk_level = '0;
            n_mic_level = '0;
            n_both_done = 1'b1;
            zeroed      = 1'b1;
        end

        // A press counts only while the other raw button is released.
        spk_toggle = !zeroed && i_spk.pressed && i_mic_btn;
        mic_toggle = !zeroed && i_mic.pressed && i_spk_btn;

        // Up steps clear mute on both channels; down steps only on the mic.
        n_spk_muted = (r_spk_muted && !i_spk.step_up) ^ spk_toggle;
        n_mic_muted = (r_mic_muted && !i_mic.step_up && !i_mic.step_dn) ^ mic_toggle;
    end

    assign o_res.volume_up_pulse   = i_spk.step_up;
    assign o_res.volume_down_pulse = i_spk.step_dn;
    assign o_res.mute_pulse        = spk_toggle;
    assign o_res.speaker_level     = n_spk_level;
    assign o_res.mic_level         = n_mic_level;
    assign o_res.speaker_muted     = n_spk_muted;
    assign o_res.mic_muted         = n_mic_muted;
    assign o_res.levels_zeroed     = zeroed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spk_level <= LEVEL_RESET;
            r_mic_level <= LEVEL_RESET;
            r_spk_muted <= 1'b0;
            r_mic_muted <= 1'b0;
            r_both_done <= 1'b0;
        end else if (i_en) begin
            r_spk_level <= n_spk_level;
            r_mic_level <= n_mic_level;
            r_spk_muted <= n_spk_muted;
            r_mic_muted <= n_mic_muted;
            r_both_done <= n_both_done;
        end
    end

endmodule

### verif/dual_encoder_volume_control_core_tb.sv
// ----------------------------------------------------------------------------
// Dual encoder volume control core testbench
// Drives pin samples and register writes, predicts every result transfer
// from an independent model of the encoder lanes, and compares field by field.
// ----------------------------------------------------------------------------
module dual_encoder_volume_control_core_tb;
    import devc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 125;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned DRAIN_CYCLES    = 6;

    // Quadrature positions in the order that counts upward, phase = {A, B}.
    localparam logic [1:0] GRAY_SEQ [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    // ------------------------------------------------------------------------
    // Scoreboard: tracks both encoder channels and queues expected results.
    // ------------------------------------------------------------------------
    class volume_scoreboard;
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [LEVEL_W-1:0]    level_step;
        logic [LEVEL_W-1:0]    level_max;
        logic [DETENT_W-1:0]   detent_count;

        logic [1:0]            last_phase [NUM_CH];
        int                    step_sum   [NUM_CH];
        logic [LEVEL_W-1:0]    level      [NUM_CH];
        logic                  muted      [NUM_CH];
        logic                  stable     [NUM_CH];
        logic                  last_raw   [NUM_CH];
        logic [TIME_W-1:0]     changed_ms [NUM_CH];
        logic                  both_done;

        t_result               expected_results [$];
        int unsigned           errors;

        function new();
            debounce_ms  = DEBOUNCE_MS_RESET;
            level_step   = LEVEL_STEP_RESET;
            level_max    = LEVEL_MAX_RESET;
            detent_count = DETENT_COUNT_RESET;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                last_phase[ch] = 2'b00;
                step_sum[ch]   = 0;
                level[ch]      = LEVEL_RESET;
                muted[ch]      = 1'b0;
                stable[ch]     = 1'b1;
                last_raw[ch]   = 1'b1;
                changed_ms[ch] = '0;
            end
            both_done = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEBOUNCE_MS:  debounce_ms  = data[DEBOUNCE_W-1:0];
                REG_LEVEL_STEP:   level_step   = data[LEVEL_W-1:0];
                REG_LEVEL_MAX:    level_max    = data[LEVEL_W-1:0];
                REG_DETENT_COUNT: detent_count = data[DETENT_W-1:0];
                default: ;
            endcase
        endfunction

        // Direction of one quadrature transition; skipped states count as none.
        function int turn_dir(logic [1:0] prev, logic [1:0] cur);
            case ({prev, cur})
                4'b0010, 4'b1011, 4'b1101, 4'b0100: return 1;
                4'b0001, 4'b0111, 4'b1110, 4'b1000: return -1;
                default: return 0;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v);
            return (v > level_max) ? level_max : v;
        endfunction

        function void note_sample(logic [IN_DATA_W-1:0] d);
            logic [TIME_W-1:0] now;
            logic [TIME_W-1:0] elapsed;
            logic [1:0]        phase   [NUM_CH];
            logic              raw     [NUM_CH];
            logic              pressed [NUM_CH];
            int                det;
            int                sum;
            t_result           r;

            now      = d[TIME_W-1:0];
            phase[0] = {d[32], d[33]};
            raw[0]   = d[34];
            phase[1] = {d[35], d[36]};
            raw[1]   = d[37];
            r        = '0;
            det      = (detent_count == 0) ? 1 : int'(detent_count);

            for (int ch = 0; ch < NUM_CH; ch++) begin
                sum = step_sum[ch] + turn_dir(last_phase[ch], phase[ch]);
                last_phase[ch] = phase[ch];
                if (sum >= det) begin
                    muted[ch] = 1'b0;
                    level[ch] = LEVEL_W'(clamp(level[ch] + level_step));
                    if (ch == 0) r.volume_up_pulse = 1'b1;
                    sum = 0;
                end else if (sum <= -det) begin
                    if (ch != 0) muted[ch] = 1'b0;
                    level[ch] = LEVEL_W'(clamp((level[ch] >= level_step) ?
                                               level[ch] - level_step : 0));
                    if (ch == 0) r.volume_down_pulse = 1'b1;
                    sum = 0;
                end
                step_sum[ch] = sum;

                // Time-based debounce of the button.
                pressed[ch] = 1'b0;
                if (raw[ch] != last_raw[ch]) begin
                    last_raw[ch]   = raw[ch];
                    changed_ms[ch] = now;
                end
                elapsed = now - changed_ms[ch];
                if (elapsed >= TIME_W'(debounce_ms) && raw[ch] != stable[ch]) begin
                    stable[ch]  = raw[ch];
                    pressed[ch] = !raw[ch];
                end
            end

            if (!(stable[0] == 1'b0 && stable[1] == 1'b0)) begin
                both_done = 1'b0;
            end else if (!both_done) begin
                level[0] = '0;
                level[1] = '0;
                both_done = 1'b1;
                r.levels_zeroed = 1'b1;
            end

            if (!r.levels_zeroed) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (pressed[ch] && raw[ch ^ 1] != 1'b0) begin
                        muted[ch] = !muted[ch];
                        if (ch == 0) r.mute_pulse = 1'b1;
                    end
                end
            end

            r.speaker_level = level[0];
            r.mic_level     = level[1];
            r.speaker_muted = muted[0];
            r.mic_muted     = muted[1];
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_result got;
            t_result want;
            got = t_result'(d[$bits(t_result)-1:0]);
            if (expected_results.size() == 0) begin
                errors++;
                $error("result transfer with no sample pending: 0x%0h", d);
                return;
            end
            want = expected_results.pop_front();
            compare_field("volume_up_pulse", want.volume_up_pulse, got.volume_up_pulse);
            compare_field("volume_down_pulse", want.volume_down_pulse,
                          got.volume_down_pulse);
            compare_field("mute_pulse", want.mute_pulse, got.mute_pulse);
            compare_field("speaker_level", want.speaker_level, got.speaker_level);
            compare_field("mic_level", want.mic_level, got.mic_level);
            compare_field("speaker_muted", want.speaker_muted, got.speaker_muted);
            compare_field("mic_muted", want.mic_muted, got.mic_muted);
            compare_field("levels_zeroed", want.levels_zeroed, got.levels_zeroed);
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    volume_scoreboard sb = new();

    // Idling controls, set per phase by the stimulus thread.
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_request  = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    // Pin generator state.
    logic [TIME_W-1:0] clock_ms = '0;
    int                enc_pos   [NUM_CH] = '{0, 0};
    int                enc_dir   [NUM_CH] = '{1, 1};
    logic              btn_state [NUM_CH] = '{1'b1, 1'b1};
    int unsigned       dt_small = 8;
    int unsigned       dt_big   = 60;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dual_encoder_volume_control_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor. Signals are sampled at the rising edge before any update of
    // that edge lands, so each handshake is seen exactly as the DUT sees it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Receiver. A long hold-off, once requested, is counted down here so that
    // the sender keeps offering samples while the result buffer fills.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("dual_encoder_volume_control_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [IN_DATA_W-1:0] pack_pins(logic [TIME_W-1:0] now,
                                                       logic [1:0] spk_ph, logic spk_btn,
                                                       logic [1:0] mic_ph, logic mic_btn);
        return {2'b00, mic_btn, mic_ph[0], mic_ph[1], spk_btn, spk_ph[0], spk_ph[1], now};
    endfunction

    // Mostly well-formed rotation and held buttons, with some skipped
    // quadrature states, contact bounce and jumps in time mixed in.
    function automatic logic [IN_DATA_W-1:0] next_pin_sample();
        logic [1:0] ph  [NUM_CH];
        logic       btn [NUM_CH];
        int unsigned roll;

        if ($urandom_range(49) == 0) begin
            btn_state[0] = 1'b0;
            btn_state[1] = 1'b0;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                enc_pos[ch] = $urandom_range(3);
            end else if (roll < 70) begin
                if ($urandom_range(9) == 0) enc_dir[ch] = -enc_dir[ch];
                enc_pos[ch] = (enc_pos[ch] + enc_dir[ch] + 4) % 4;
            end
            ph[ch] = GRAY_SEQ[enc_pos[ch]];
            if ($urandom_range(99) < 5) btn_state[ch] = !btn_state[ch];
            btn[ch] = btn_state[ch];
            if ($urandom_range(99) < 3) btn[ch] = !btn[ch];
        end

        roll = $urandom_range(99);
        if (roll < 2) clock_ms = $urandom();
        else if (roll < 12) clock_ms = clock_ms + $urandom_range(dt_big);
        else clock_ms = clock_ms + $urandom_range(dt_small);

        return pack_pins(clock_ms, ph[0], btn[0], ph[1], btn[1]);
    endfunction

    task automatic send_sample(input logic [IN_DATA_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_cfg(input int unsigned db, input int unsigned step,
                               input int unsigned lmax, input int unsigned det);
        write_cfg(REG_DEBOUNCE_MS, db);
        write_cfg(REG_LEVEL_STEP, step);
        write_cfg(REG_LEVEL_MAX, lmax);
        write_cfg(REG_DETENT_COUNT, det);
        i_cfg_valid <= 1'b0;
        // Scale time steps so that presses outlast the debounce window.
        dt_small = db / 4 + 3;
        dt_big   = db * 2 + 10;
    endtask

    // Stop offering samples and wait until every result has come back. The
    // first edge lets the monitor log a sample accepted at the previous edge.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A low maximum shows that the reset level of 20 stays
        // put until the first step and then drops to the maximum.
        write_cfg(REG_LEVEL_MAX, 16);
        i_cfg_valid <= 1'b0;
        send_sample(pack_pins(32'd0, 2'b00, 1'b1, 2'b00, 1'b1));
        // Speaker turns up one full detent.
        send_sample(pack_pins(32'd1, 2'b10, 1'b1, 2'b00, 1'b1));
        send_sample(pack_pins(32'd2, 2'b11, 1'b1, 2'b00, 1'b1));
        send_sample(pack_pins(32'd3, 2'b01, 1'b1, 2'b00, 1'b1));
        send_sample(pack_pins(32'd4, 2'b00, 1'b1, 2'b00, 1'b1));
        // Microphone turns down one full detent.
        send_sample(pack_pins(32'd4, 2'b00, 1'b1, 2'b01, 1'b1));
        send_sample(pack_pins(32'd4, 2'b00, 1'b1, 2'b11, 1'b1));
        send_sample(pack_pins(32'd4, 2'b00, 1'b1, 2'b10, 1'b1));
        send_sample(pack_pins(32'd4, 2'b00, 1'b1, 2'b00, 1'b1));
        // Skipped quadrature states on both encoders count as no motion.
        send_sample(pack_pins(32'd5, 2'b11, 1'b1, 2'b11, 1'b1));
        send_sample(pack_pins(32'd6, 2'b00, 1'b1, 2'b00, 1'b1));
        // Lone speaker press, held past the debounce window, toggles mute.
        send_sample(pack_pins(32'd10, 2'b00, 1'b0, 2'b00, 1'b1));
        send_sample(pack_pins(32'd35, 2'b00, 1'b0, 2'b00, 1'b1));
        // Microphone press while the speaker is down: no toggle, both levels
        // are zeroed once and then held at zero.
        send_sample(pack_pins(32'd40, 2'b00, 1'b0, 2'b00, 1'b0));
        send_sample(pack_pins(32'd65, 2'b00, 1'b0, 2'b00, 1'b0));
        send_sample(pack_pins(32'd70, 2'b00, 1'b0, 2'b00, 1'b0));
        send_sample(pack_pins(32'd75, 2'b00, 1'b1, 2'b00, 1'b1));
        send_sample(pack_pins(32'd100, 2'b00, 1'b1, 2'b00, 1'b1));
        // Speaker up step while muted clears the mute flag.
        send_sample(pack_pins(32'd101, 2'b10, 1'b1, 2'b00, 1'b1));
        send_sample(pack_pins(32'd102, 2'b11, 1'b1, 2'b00, 1'b1));
        send_sample(pack_pins(32'd103, 2'b01, 1'b1, 2'b00, 1'b1));
        send_sample(pack_pins(32'd104, 2'b00, 1'b1, 2'b00, 1'b1));
        // Time at its top value and then wrapping to zero.
        send_sample(pack_pins(32'hFFFF_FFFF, 2'b11, 1'b1, 2'b11, 1'b1));
        send_sample(pack_pins(32'd0, 2'b00, 1'b1, 2'b00, 1'b1));

        // Random phases, each with its own settings and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (p == 4) write_cfg(CFG_IDX_W'(int'(REG_DETENT_COUNT) + 1 +
                                  $urandom_range((1 << CFG_IDX_W) - 2 -
                                                 int'(REG_DETENT_COUNT))),
                                  $urandom());
            case (p)
                0: program_cfg(0, 200, 255, 1);
                1: program_cfg((1 << DEBOUNCE_W) - 1, 1, 1, 7);
                2: program_cfg(3, 0, 0, 0);
                5: program_cfg(DEBOUNCE_MS_RESET, LEVEL_STEP_RESET, LEVEL_MAX_RESET,
                               DETENT_COUNT_RESET);
                default: program_cfg($urandom_range(40), $urandom_range(1, 200),
                                     $urandom_range(1, 255), $urandom_range(1, 7));
            endcase

            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
                default: begin src_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            clock_ms = (p == 3) ? 32'hFFFF_FE00 : $urandom();

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == 40 && (p == 0 || p == 6)) hold_request = LONG_HOLD;
                if (n == 70) wait_drained();
                send_sample(next_pin_sample());
            end
        end

        wait_drained();
        if (sb.pending() != 0) begin
            sb.errors++;
            $error("%0d expected results never arrived", sb.pending());
        end
        if (sb.errors == 0) begin
            $display("dual_encoder_volume_control_core_tb: PASS");
        end else begin
            $display("dual_encoder_volume_control_core_tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/devc_pkg.sv
hdl/devc_lane.sv
hdl/devc_merge.sv
hdl/dual_encoder_volume_control_core.sv
verif/dual_encoder_volume_control_core_tb.sv
